/* hdl/peak_limiter_instant_attack_macros.svh */
// Assertion macros for the peak limiter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PEAK_LIMITER_INSTANT_ATTACK_MACROS_SVH
`define PEAK_LIMITER_INSTANT_ATTACK_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define PLI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("peak limiter check failed");

// Next-cycle implication, disabled during reset.
`define PLI_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("peak limiter check failed");

`else

`define PLI_ASSERT_IMP(label, clk, rst, ante, cons)
`define PLI_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/pli_pkg.sv */
// Package for the peak limiter: widths, reset values, register indexes,
// microcode types and the control store. No dependencies.
`default_nettype none

package pli_pkg;

  localparam int SAMPLE_W   = 24;            // Q3.20 sample
  localparam int THR_W      = SAMPLE_W - 1;  // threshold is a magnitude
  localparam int GAIN_FRAC  = 23;            // gain Q0.23
  localparam int GAIN_W     = GAIN_FRAC + 1; // unity needs one more bit
  localparam int COEF_FRAC  = 24;            // coefficient Q0.24
  localparam int COEF_W     = COEF_FRAC + 1;
  localparam int PROD_W     = COEF_W + GAIN_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COEF_W;
  localparam int DIV_STEPS  = GAIN_FRAC;     // quotient bits of threshold/level
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(1036572);
  localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(7607);
  localparam logic [COEF_W-1:0] COEF_ONE   = COEF_W'(1) << COEF_FRAC;
  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1) << GAIN_FRAC;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = CFG_IDX_W'(1);

  // Program steps
  typedef enum logic [2:0] {
    S_LOAD, S_CHECK, S_DIV, S_RELMUL, S_RELADD, S_OUTMUL, S_EMIT
  } step_t;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_LOAD, OP_CHECK, OP_DIV, OP_RELMUL, OP_RELADD, OP_OUTMUL, OP_EMIT
  } op_t;

  // Branch conditions
  typedef enum logic [2:0] {
    JC_NEVER, JC_IN_TAKEN, JC_OVER_THR, JC_COUNT_NZ, JC_ATTACK, JC_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t on_true;
    step_t on_false;
  } ucode_t;

  // Control store: one word per step, two-way branch on the condition.
  function automatic ucode_t pli_ucode(input step_t pc);
    ucode_t w;
    case (pc)
      S_LOAD:   w = '{OP_LOAD,   JC_IN_TAKEN, S_CHECK,  S_LOAD};
      S_CHECK:  w = '{OP_CHECK,  JC_OVER_THR, S_DIV,    S_RELMUL};
      S_DIV:    w = '{OP_DIV,    JC_COUNT_NZ, S_DIV,    S_RELMUL};
      S_RELMUL: w = '{OP_RELMUL, JC_ATTACK,   S_OUTMUL, S_RELADD};
      S_RELADD: w = '{OP_RELADD, JC_NEVER,    S_OUTMUL, S_OUTMUL};
      S_OUTMUL: w = '{OP_OUTMUL, JC_NEVER,    S_EMIT,   S_EMIT};
      S_EMIT:   w = '{OP_EMIT,   JC_OUT_FREE, S_LOAD,   S_EMIT};
      default:  w = '{OP_LOAD,   JC_NEVER,    S_LOAD,   S_LOAD};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hdl/pli_ifs.sv */
// Valid/ready channel interfaces for the peak limiter: sample input,
// limited result and configuration write. Depends on pli_pkg.
`default_nettype none

interface pli_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pli_pkg::SAMPLE_W-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface pli_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pli_pkg::SAMPLE_W-1:0] sample_out;
  logic        [pli_pkg::GAIN_W-1:0]   gain_now;
  modport source (output valid, output sample_out, output gain_now, input ready);
  modport sink   (input valid, input sample_out, input gain_now, output ready);
endinterface

interface pli_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pli_pkg::CFG_IDX_W-1:0]     index;
  logic [pli_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/peak_limiter_instant_attack.sv */
// Peak limiter top level: microcoded sequencer, divider, gain and output path.
// Depends on pli_pkg, pli_ifs.sv and peak_limiter_instant_attack_macros.svh.
//
// Peak limiter with instant attack and exponential release. Each input word
// is one signed Q3.20 sample; each produces exactly one output word with the
// limited sample (clamped to +/- threshold) and the Q0.23 gain applied to it.
// A short program in a read-only control store steps a plain datapath: load,
// compare level against threshold, restoring division threshold/level one
// quotient bit per cycle, release multiply, release add and clamp, output
// multiply, emit. A sample at or under the threshold skips the divider; one
// over the threshold runs the divider loop for all 23 quotient bits, and on
// attack skips the release add. The next sample is accepted the cycle after
// the result enters the output register, while that result may still be
// waiting for the sink; emit holds as long as the previous word is still
// untaken. Configuration writes (index 0 threshold Q3.20, index 1 release
// coefficient Q0.24, saturated to 1.0 in use) are always accepted and belong
// in idle time between samples.
`default_nettype none

`include "peak_limiter_instant_attack_macros.svh"

module peak_limiter_instant_attack (
  input  wire        clk,
  input  wire        rst,
  pli_in_if.sink     din,
  pli_out_if.source  dout,
  pli_cfg_if.sink    cfg
);
  import pli_pkg::*;

  // Sequencer
  step_t  pc;
  step_t  pc_next;
  ucode_t uw;
  logic   cond_true;

  // Configuration registers
  logic [THR_W-1:0]  thr;
  logic [COEF_W-1:0] coef;

  // Datapath registers
  logic [SAMPLE_W-1:0] level;
  logic                neg;
  logic [SAMPLE_W-1:0] rem;
  logic [CNT_W-1:0]    count;
  logic [GAIN_W-1:0]   target;
  logic [GAIN_W-1:0]   gain;
  logic [PROD_W-1:0]   prod;

  // Output register
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic [GAIN_W-1:0]          out_gain;

  // Datapath combinational values
  logic                in_taken;
  logic                out_free;
  logic                over_thr;
  logic                attack;
  logic [SAMPLE_W-1:0] x_abs;
  logic [SAMPLE_W:0]   rem2;
  logic [SAMPLE_W:0]   rem_sub;
  logic                q_bit;
  logic [COEF_W-1:0]   coef_sat;
  logic [GAIN_W-1:0]   diff;
  logic [GAIN_W+1:0]   rel_sum;
  logic [GAIN_W-1:0]   rel_gain;
  logic [SAMPLE_W+GAIN_W-1:0] out_prod;
  logic [PROD_W-GAIN_FRAC-1:0] mag_full;
  logic [THR_W-1:0]    mag;
  logic [SAMPLE_W-1:0] y;

  // Handshakes
  assign cfg.ready   = 1'b1;
  assign din.ready   = (pc == S_LOAD);
  assign in_taken    = din.valid && din.ready;
  assign out_free    = !out_valid || dout.ready;
  assign dout.valid      = out_valid;
  assign dout.sample_out = out_sample;
  assign dout.gain_now   = out_gain;

  // Fetch the control word for this step
  assign uw = pli_ucode(pc);

  // Datapath arithmetic
  always_comb begin
    x_abs    = din.sample_in[SAMPLE_W-1] ? (SAMPLE_W'(0) - SAMPLE_W'(din.sample_in))
                                         : SAMPLE_W'(din.sample_in);
    over_thr = level > {1'b0, thr};
    // restoring divider: shift remainder, subtract level when it fits
    rem2     = {rem, 1'b0};
    rem_sub  = rem2 - {1'b0, level};
    q_bit    = rem2 >= {1'b0, level};
    attack   = target < gain;
    coef_sat = (coef > COEF_ONE) ? COEF_ONE : coef;
    diff     = target - gain;
    rel_sum  = {2'b00, gain} + {1'b0, prod[PROD_W-1:COEF_FRAC]};
    rel_gain = (rel_sum > {2'b00, target}) ? target : rel_sum[GAIN_W-1:0];
    out_prod = level * gain;
    mag_full = prod[PROD_W-1:GAIN_FRAC];
    mag      = (mag_full > {{(PROD_W-GAIN_FRAC-THR_W){1'b0}}, thr})
               ? thr : mag_full[THR_W-1:0];
    y        = neg ? (SAMPLE_W'(0) - {1'b0, mag}) : {1'b0, mag};
  end

  // Branch condition select
  always_comb begin
    case (uw.cond)
      JC_NEVER:    cond_true = 1'b0;
      JC_IN_TAKEN: cond_true = in_taken;
      JC_OVER_THR: cond_true = over_thr;
      JC_COUNT_NZ: cond_true = (count != '0);
      JC_ATTACK:   cond_true = attack;
      JC_OUT_FREE: cond_true = out_free;
      default:     cond_true = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    pc_next = cond_true ? uw.on_true : uw.on_false;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      thr  <= THR_RESET;
      coef <= COEF_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_THRESHOLD: thr  <= cfg.data[THR_W-1:0];
        CFG_RELEASE:   coef <= cfg.data[COEF_W-1:0];
        default:       ;
      endcase
    end
  end

  // Stored gain: state, reset to unity
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_UNITY;
    end else begin
      case (uw.op)
        OP_RELMUL: if (attack) gain <= target;   // instant attack
        OP_RELADD: gain <= rel_gain;             // release, never past target
        default:   ;
      endcase
    end
  end

  // Payload datapath registers
  always_ff @(posedge clk) begin
    case (uw.op)
      OP_LOAD: begin
        if (in_taken) begin
          level <= x_abs;
          neg   <= din.sample_in[SAMPLE_W-1];
        end
      end
      OP_CHECK: begin
        if (over_thr) begin
          target <= '0;
          rem    <= {1'b0, thr};
          count  <= CNT_W'(DIV_STEPS - 1);
        end else begin
          target <= GAIN_UNITY;
        end
      end
      OP_DIV: begin
        rem    <= q_bit ? rem_sub[SAMPLE_W-1:0] : rem2[SAMPLE_W-1:0];
        target <= {target[GAIN_W-2:0], q_bit};
        count  <= count - CNT_W'(1);
      end
      OP_RELMUL: begin
        prod <= coef_sat * diff;
      end
      OP_OUTMUL: begin
        prod <= {{(PROD_W-SAMPLE_W-GAIN_W){1'b0}}, out_prod};
      end
      default: ;
    endcase
  end

  // Output register: load on emit, hold until the sink takes the word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.op == OP_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.op == OP_EMIT && out_free) begin
      out_sample <= signed'(y);
      out_gain   <= gain;
    end
  end

  // Checks
  `PLI_ASSERT_IMP(a_gain_le_unity, clk, rst, 1'b1, gain <= GAIN_UNITY)
  `PLI_ASSERT_IMP(a_div_rem_below_level, clk, rst, pc == S_DIV, rem < level)
  `PLI_ASSERT_NXT(a_release_no_overshoot, clk, rst, pc == S_RELADD, gain <= target)
  `PLI_ASSERT_NXT(a_emit_carries_gain, clk, rst, (pc == S_EMIT) && out_free,
                  out_valid && (out_gain == gain))

endmodule

`default_nettype wire
